// ===== hdl/ray_slope_ground_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the ground classifier sequencer (rsgc_ctrl)
// Same-cycle and next-cycle implications on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef RAY_SLOPE_GROUND_CLASSIFIER_MACROS_SVH
`define RAY_SLOPE_GROUND_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSGC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSGC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rsgc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsgc_pkg
// Types, register codes and reset values of the ray slope ground classifier.
// ----------------------------------------------------------------------------
package rsgc_pkg;

  localparam int RADIUS_BITS_DEF = 18;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [13:0] SENSOR_HEIGHT_RST = 14'd2200;
  localparam logic [9:0]  MIN_STEP_RST      = 10'd50;
  localparam logic [13:0] BIN_SPACING_RST   = 14'd200;
  localparam logic [13:0] FAR_GAP_RST       = 14'd200;
  localparam logic [17:0] LOCAL_TAN_RST     = 18'd9211;
  localparam logic [17:0] GLOBAL_TAN_RST    = 18'd5734;
  localparam logic [31:0] INV_RANGE_RST     = 32'd42949673;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SENSOR_HEIGHT = 3'd0,
    REG_MIN_STEP      = 3'd1,
    REG_BIN_SPACING   = 3'd2,
    REG_FAR_GAP       = 3'd3,
    REG_LOCAL_TAN     = 3'd4,
    REG_GLOBAL_TAN    = 3'd5,
    REG_INV_RANGE     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [13:0] sensor_height_mm;
    logic [9:0]  min_height_step_mm;
    logic [13:0] bin_spacing_mm;
    logic [13:0] far_gap_mm;
    logic [17:0] local_slope_tan;
    logic [17:0] global_slope_tan;
    logic [31:0] inv_range_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] height_mm;
    logic [17:0]        radius_mm;
    logic               ray_start;
    logic [15:0]        point_tag;
  } point_t;

  typedef struct packed {
    logic        is_ground;
    logic [15:0] tag_out;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic compute;
    logic finish;
  } cmd_t;

endpackage

// ===== hdl/ray_slope_ground_classifier.sv =====
// ----------------------------------------------------------------------------
// ray_slope_ground_classifier
// Steps: a point is captured, its products are registered in the product step,
// and the decision registers the result once the output slot is free. The capture
// of the next point overlaps the decision step, which holds the band multiply.
// Reset: configuration registers take their default values, the ray chain starts at minus
// sensor height, radius zero, not ground; no clearing pass.
// ----------------------------------------------------------------------------
module ray_slope_ground_classifier #(
  parameter int RADIUS_BITS = rsgc_pkg::RADIUS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_ready,
  input  rsgc_pkg::point_t                    point,
  output logic                                result_valid,
  input  logic                                result_ready,
  output rsgc_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rsgc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rsgc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  rsgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsgc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  rsgc_dp #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .point  (point),
    .result (result)
  );

endmodule

// ===== hdl/rsgc_cfg.sv =====
// ----------------------------------------------------------------------------
// rsgc_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module rsgc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsgc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rsgc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output rsgc_pkg::cfg_t                       cfg
);
  import rsgc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_height_mm   <= SENSOR_HEIGHT_RST;
      cfg.min_height_step_mm <= MIN_STEP_RST;
      cfg.bin_spacing_mm     <= BIN_SPACING_RST;
      cfg.far_gap_mm         <= FAR_GAP_RST;
      cfg.local_slope_tan    <= LOCAL_TAN_RST;
      cfg.global_slope_tan   <= GLOBAL_TAN_RST;
      cfg.inv_range_limit    <= INV_RANGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_SENSOR_HEIGHT: cfg.sensor_height_mm   <= cfg_data[13:0];
        REG_MIN_STEP:      cfg.min_height_step_mm <= cfg_data[9:0];
        REG_BIN_SPACING:   cfg.bin_spacing_mm     <= cfg_data[13:0];
        REG_FAR_GAP:       cfg.far_gap_mm         <= cfg_data[13:0];
        REG_LOCAL_TAN:     cfg.local_slope_tan    <= cfg_data[17:0];
        REG_GLOBAL_TAN:    cfg.global_slope_tan   <= cfg_data[17:0];
        REG_INV_RANGE:     cfg.inv_range_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rsgc_dp.sv =====
// ----------------------------------------------------------------------------
// rsgc_dp
// Datapath: ray chain state, gap step, slope products and ground decision.
// ----------------------------------------------------------------------------
module rsgc_dp #(
  parameter int RADIUS_BITS = rsgc_pkg::RADIUS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rsgc_pkg::cfg_t   cfg,
  input  rsgc_pkg::cmd_t   cmd,
  input  rsgc_pkg::point_t point,
  output rsgc_pkg::result_t result
);
  import rsgc_pkg::*;

  localparam int RB   = RADIUS_BITS;
  localparam int CW   = ((RB > 14) ? RB : 14) + 1;
  localparam int LOCW = (RB + 20 > 34) ? RB + 20 : 34;
  localparam int BW   = (RB + 35 > 49) ? RB + 35 : 49;
  localparam logic [RB+31:0] ONE_Q32 = (RB + 32)'(64'd1 << 32);
  localparam logic signed [16:0] LAST_HEIGHT_RST = -$signed({3'b000, SENSOR_HEIGHT_RST});

  // chain state
  logic [RB-1:0]        last_radius;
  logic signed [16:0]   last_height;
  logic                 last_was_ground;

  // capture stage
  logic [RB-1:0]        r_in;
  logic [RB-1:0]        base_radius;
  logic signed [16:0]   base_height;
  logic signed [RB:0]   dr;
  logic signed [CW-1:0] dr_ext;
  logic signed [17:0]   dh;
  logic signed [17:0]   min_step;
  logic signed [17:0]   dh_adj;
  logic [16:0]          adh;
  logic signed [16:0]   sh;
  logic [15:0]          ash;
  logic                 gap;
  logic                 far;

  logic [RB-1:0]        r_q;
  logic signed [RB:0]   dr_q;
  logic [16:0]          adh_q;
  logic [15:0]          ash_q;
  logic                 far_q;
  logic                 ray_q;
  logic [15:0]          tag_q;

  // product stage
  logic [RB+31:0]       prod_f;
  logic [RB+17:0]       prod_g;
  logic signed [RB+19:0] loc_rhs;

  // decision
  logic                 f_ok;
  logic [32:0]          f;
  logic [16:0]          q;
  logic [RB+34:0]       band_rhs;
  logic [47:0]          band_lhs;
  logic [32:0]          loc_lhs;
  logic                 band;
  logic                 loc_ok;
  logic                 chain_ground;
  logic                 ground;

  assign r_in        = RB'(point.radius_mm);
  assign base_radius = point.ray_start ? '0 : last_radius;
  assign base_height = point.ray_start ? -$signed({3'b000, cfg.sensor_height_mm})
                                       : last_height;
  assign dr     = $signed({1'b0, r_in}) - $signed({1'b0, base_radius});
  assign dr_ext = CW'(dr);
  assign dh     = 18'(point.height_mm) - 18'(base_height);
  assign min_step = $signed({8'b0, cfg.min_height_step_mm});
  assign gap    = dr_ext > $signed(CW'({1'b0, cfg.bin_spacing_mm}));
  assign far    = dr_ext > $signed(CW'({1'b0, cfg.far_gap_mm}));
  assign dh_adj = (gap && (dh < min_step)) ? min_step : dh;
  assign adh    = dh_adj[17] ? 17'(-dh_adj) : 17'(dh_adj);
  assign sh     = $signed({3'b000, cfg.sensor_height_mm}) + 17'(point.height_mm);
  assign ash    = sh[16] ? 16'(-sh) : 16'(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_radius <= '0;
      last_height <= LAST_HEIGHT_RST;
    end else if (cmd.capture) begin
      last_radius <= r_in;
      last_height <= 17'(point.height_mm);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_q   <= r_in;
      dr_q  <= dr;
      adh_q <= adh;
      ash_q <= ash;
      far_q <= far;
      ray_q <= point.ray_start;
      tag_q <= point.point_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      prod_f  <= r_q * cfg.inv_range_limit;
      prod_g  <= r_q * cfg.global_slope_tan;
      loc_rhs <= dr_q * $signed({1'b0, cfg.local_slope_tan});
    end
  end

  // band factor is only used when it is not negative
  assign f_ok     = prod_f <= ONE_Q32;
  assign f        = 33'(ONE_Q32) - prod_f[32:0];
  assign q        = f[32:16];
  assign band_rhs = prod_g * q;
  assign band_lhs = {ash_q, 32'b0};
  assign band     = f_ok && (BW'(band_lhs) <= BW'(band_rhs));
  assign loc_lhs  = {adh_q, 16'b0};
  assign loc_ok   = $signed(LOCW'({1'b0, loc_lhs})) <= $signed(LOCW'(loc_rhs));
  assign chain_ground = ray_q ? 1'b0 : last_was_ground;
  assign ground   = loc_ok ? (chain_ground || band) : (far_q && band);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_was_ground <= 1'b0;
    end else if (cmd.finish) begin
      last_was_ground <= ground;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.is_ground <= ground;
      result.tag_out   <= tag_q;
    end
  end

endmodule

// ===== hdl/rsgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsgc_ctrl
// Sequencer: capture, product and decision steps plus the output holding slot.
// ----------------------------------------------------------------------------
`include "ray_slope_ground_classifier_macros.svh"

module rsgc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           point_valid,
  output logic           point_ready,
  output logic           result_valid,
  input  logic           result_ready,
  output rsgc_pkg::cmd_t cmd
);
  import rsgc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   result_valid_next;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    point_ready = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.compute = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish  = 1'b1;
          point_ready = 1'b1;
          if (point_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_MUL;
          end else begin
            state_next  = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  `RSGC_ASSERT_NXT(a_capture_then_mul, clk, rst, cmd.capture, state == ST_MUL, "capture not followed by product step")
  `RSGC_ASSERT_NXT(a_mul_then_fin, clk, rst, state == ST_MUL, state == ST_FIN, "product step not followed by decision")
  `RSGC_ASSERT_NXT(a_finish_shows, clk, rst, cmd.finish, result_valid, "finished result not presented")
  `RSGC_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.finish, !result_valid || result_ready, "pending result overwritten")

endmodule
